// ===== design/cats_pkg.sv =====
// ----------------------------------------------------------------------------
// cats_pkg: shared types and constants of the coil actuator test sequencer
// Sequencer states, register indexes, configuration, context and beat types.
// ----------------------------------------------------------------------------
package cats_pkg;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'd0,
		ST_START  = 3'd1,
		ST_ON     = 3'd2,
		ST_OFF    = 3'd3,
		ST_STOP   = 3'd4,
		ST_END    = 3'd5,
		ST_RECONF = 3'd6
	} seq_state_t;

	typedef enum logic [2:0] {
		REG_ON_TIME         = 3'd0,
		REG_OFF_TIME        = 3'd1,
		REG_TOTAL_TIME      = 3'd2,
		REG_IDLE_HOLD       = 3'd3,
		REG_CODE_COIL_ONE   = 3'd4,
		REG_CODE_COIL_TWO   = 3'd5,
		REG_CODE_COIL_THREE = 3'd6,
		REG_CODE_COIL_FOUR  = 3'd7
	} cfg_reg_t;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned TICK_W      = 13;
	localparam int unsigned PULSE_W     = 17;

	localparam logic [TICK_W-1:0] TICK_LIMIT     = 13'd5000;
	localparam logic [15:0]       INTERVAL_LIMIT = 16'd50000;
	localparam logic [9:0]        PULSE_SCALE    = 10'd625;

	localparam logic [7:0] CODE_ONE_RST   = 8'd1;
	localparam logic [7:0] CODE_TWO_RST   = 8'd2;
	localparam logic [7:0] CODE_THREE_RST = 8'd3;
	localparam logic [7:0] CODE_FOUR_RST  = 8'd4;

	localparam logic [1:0] COIL_FOUR = 2'd3;

	typedef struct packed {
		logic [7:0]  on_time;
		logic [15:0] off_time;
		logic [15:0] total_time;
		logic [15:0] idle_hold;
		logic [7:0]  code_coil_one;
		logic [7:0]  code_coil_two;
		logic [7:0]  code_coil_three;
		logic [7:0]  code_coil_four;
	} cfg_t;

	typedef struct packed {
		seq_state_t        seq_state;
		seq_state_t        last_state;
		logic [7:0]        last_code;
		logic [TICK_W-1:0] hold_count;
		logic [TICK_W-1:0] remaining_ticks;
		logic [7:0]        command_time;
		logic [15:0]       interval_time;
		logic              relay_flag;
		logic              complete_flag;
	} ctx_t;

	typedef struct packed {
		logic       test_enable;
		logic [7:0] test_code;
		logic       driver_in_test_mode;
		logic       four_cylinder_engine;
	} tick_t;

	typedef struct packed {
		seq_state_t         test_state;
		logic               relay_command;
		logic               test_complete;
		logic [3:0]         coil_done;
		logic               pulse_start;
		logic [1:0]         pulse_coil;
		logic [PULSE_W-1:0] pulse_time;
		logic               enter_test_mode;
		logic               leave_test_mode;
	} result_t;

endpackage

// ===== design/cats_tick_if.sv =====
// ----------------------------------------------------------------------------
// cats_tick_if: tick channel
// One beat per sequencer tick, carrying the request and driver status.
// ----------------------------------------------------------------------------
interface cats_tick_if;
	logic       valid;
	logic       ready;
	logic       test_enable;
	logic [7:0] test_code;
	logic       driver_in_test_mode;
	logic       four_cylinder_engine;

	modport source (output valid, test_enable, test_code, driver_in_test_mode,
		four_cylinder_engine, input ready);
	modport sink (input valid, test_enable, test_code, driver_in_test_mode,
		four_cylinder_engine, output ready);
endinterface

// ===== design/cats_result_if.sv =====
// ----------------------------------------------------------------------------
// cats_result_if: result channel
// One beat per tick with the sequencer state and the driver requests.
// ----------------------------------------------------------------------------
interface cats_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  test_state;
	logic        relay_command;
	logic        test_complete;
	logic [3:0]  coil_done;
	logic        pulse_start;
	logic [1:0]  pulse_coil;
	logic [16:0] pulse_time;
	logic        enter_test_mode;
	logic        leave_test_mode;

	modport source (output valid, test_state, relay_command, test_complete, coil_done,
		pulse_start, pulse_coil, pulse_time, enter_test_mode, leave_test_mode,
		input ready);
	modport sink (input valid, test_state, relay_command, test_complete, coil_done,
		pulse_start, pulse_coil, pulse_time, enter_test_mode, leave_test_mode,
		output ready);
endinterface

// ===== design/cats_cfg_if.sv =====
// ----------------------------------------------------------------------------
// cats_cfg_if: configuration write channel
// Each beat writes one register, selected by index.
// ----------------------------------------------------------------------------
interface cats_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== design/cats_regs.sv =====
// ----------------------------------------------------------------------------
// cats_regs: configuration register file
// Holds the test timings and the four coil codes, written one beat at a time.
// ----------------------------------------------------------------------------
module cats_regs (
	input  logic          clk,
	input  logic          arst_n,
	cats_cfg_if.sink      cfg,
	output cats_pkg::cfg_t regs
);

	cats_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.on_time         <= '0;
			regs_q.off_time        <= '0;
			regs_q.total_time      <= '0;
			regs_q.idle_hold       <= '0;
			regs_q.code_coil_one   <= cats_pkg::CODE_ONE_RST;
			regs_q.code_coil_two   <= cats_pkg::CODE_TWO_RST;
			regs_q.code_coil_three <= cats_pkg::CODE_THREE_RST;
			regs_q.code_coil_four  <= cats_pkg::CODE_FOUR_RST;
		end else if (cfg.valid) begin
			unique case (cats_pkg::cfg_reg_t'(cfg.index))
				cats_pkg::REG_ON_TIME:         regs_q.on_time         <= cfg.data[7:0];
				cats_pkg::REG_OFF_TIME:        regs_q.off_time        <= cfg.data;
				cats_pkg::REG_TOTAL_TIME:      regs_q.total_time      <= cfg.data;
				cats_pkg::REG_IDLE_HOLD:       regs_q.idle_hold       <= cfg.data;
				cats_pkg::REG_CODE_COIL_ONE:   regs_q.code_coil_one   <= cfg.data[7:0];
				cats_pkg::REG_CODE_COIL_TWO:   regs_q.code_coil_two   <= cfg.data[7:0];
				cats_pkg::REG_CODE_COIL_THREE: regs_q.code_coil_three <= cfg.data[7:0];
				cats_pkg::REG_CODE_COIL_FOUR:  regs_q.code_coil_four  <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== design/cats_step.sv =====
// ----------------------------------------------------------------------------
// cats_step: next-state and result logic for one tick
// Advances the sequencer once and derives the driver requests from the new state.
// ----------------------------------------------------------------------------
module cats_step #(
	parameter int unsigned SAMPLE_PERIOD = 10
) (
	input  cats_pkg::cfg_t    regs,
	input  cats_pkg::ctx_t    ctx,
	input  cats_pkg::tick_t   tick,
	output cats_pkg::ctx_t    ctx_nxt,
	output cats_pkg::result_t res
);

	localparam logic [7:0]  SP8  = 8'(SAMPLE_PERIOD);
	localparam logic [15:0] SP16 = {8'd0, SP8};
	localparam logic [16:0] SP17 = {9'd0, SP8};

	logic                          is_coil;
	logic [1:0]                    idx;
	logic                          ena;
	logic                          code_changed;
	logic [cats_pkg::TICK_W-1:0]   total_clamped;
	logic [cats_pkg::TICK_W-1:0]   hold_clamped;
	logic [16:0]                   off_sum;
	logic [16:0]                   off_left;
	logic [15:0]                   interval_load;
	logic                          may_pulse;
	logic [17:0]                   pulse_prod;

	// First matching code wins when codes are equal.
	always_comb begin
		is_coil = 1'b1;
		idx     = 2'd0;
		priority if (tick.test_code == regs.code_coil_one) idx = 2'd0;
		else if (tick.test_code == regs.code_coil_two)     idx = 2'd1;
		else if (tick.test_code == regs.code_coil_three)   idx = 2'd2;
		else if (tick.test_code == regs.code_coil_four)    idx = 2'd3;
		else is_coil = 1'b0;
	end

	assign ena          = tick.test_enable && is_coil;
	assign code_changed = tick.test_code != ctx.last_code;

	assign total_clamped = (regs.total_time > {3'd0, cats_pkg::TICK_LIMIT}) ?
		cats_pkg::TICK_LIMIT : regs.total_time[cats_pkg::TICK_W-1:0];
	assign hold_clamped  = (regs.idle_hold > {3'd0, cats_pkg::TICK_LIMIT}) ?
		cats_pkg::TICK_LIMIT : regs.idle_hold[cats_pkg::TICK_W-1:0];

	assign off_sum       = {9'd0, ctx.command_time} + {1'b0, regs.off_time};
	assign off_left      = (off_sum > SP17) ? off_sum - SP17 : '0;
	assign interval_load = (off_left > {1'b0, cats_pkg::INTERVAL_LIMIT}) ?
		cats_pkg::INTERVAL_LIMIT : off_left[15:0];

	always_comb begin
		ctx_nxt = ctx;
		unique case (ctx.seq_state)
			cats_pkg::ST_IDLE: begin
				if (ena && ctx.hold_count == '0) begin
					ctx_nxt.seq_state     = cats_pkg::ST_START;
					ctx_nxt.relay_flag    = 1'b1;
					ctx_nxt.complete_flag = 1'b0;
				end else if (ctx.hold_count != '0) begin
					ctx_nxt.hold_count = ctx.hold_count - 1'b1;
				end
			end
			cats_pkg::ST_START: begin
				if (ena) begin
					ctx_nxt.remaining_ticks = total_clamped;
					ctx_nxt.relay_flag      = 1'b1;
					ctx_nxt.complete_flag   = 1'b0;
					ctx_nxt.seq_state       = cats_pkg::ST_ON;
					ctx_nxt.command_time    = regs.on_time;
				end
			end
			cats_pkg::ST_ON, cats_pkg::ST_OFF: begin
				if (!ena || code_changed) begin
					ctx_nxt.seq_state     = cats_pkg::ST_STOP;
					ctx_nxt.relay_flag    = 1'b1;
					ctx_nxt.complete_flag = 1'b0;
					ctx_nxt.command_time  = '0;
				end else if (ctx.remaining_ticks <= 13'd1) begin
					ctx_nxt.seq_state     = cats_pkg::ST_RECONF;
					ctx_nxt.relay_flag    = 1'b1;
					ctx_nxt.complete_flag = 1'b0;
				end else begin
					ctx_nxt.remaining_ticks = ctx.remaining_ticks - 1'b1;
					if (ctx.seq_state == cats_pkg::ST_ON) begin
						if (ctx.command_time <= SP8) begin
							ctx_nxt.seq_state     = cats_pkg::ST_OFF;
							ctx_nxt.interval_time = interval_load;
							ctx_nxt.command_time  = '0;
						end else begin
							ctx_nxt.command_time = ctx.command_time - SP8;
						end
					end else begin
						if (ctx.interval_time <= SP16) begin
							ctx_nxt.seq_state    = cats_pkg::ST_ON;
							ctx_nxt.command_time = regs.on_time;
						end else begin
							ctx_nxt.interval_time = ctx.interval_time - SP16;
						end
					end
				end
			end
			cats_pkg::ST_STOP: begin
				ctx_nxt.hold_count    = hold_clamped;
				ctx_nxt.seq_state     = cats_pkg::ST_IDLE;
				ctx_nxt.relay_flag    = 1'b0;
				ctx_nxt.complete_flag = 1'b0;
			end
			cats_pkg::ST_END: begin
				if (ena) begin
					ctx_nxt.hold_count    = hold_clamped;
					ctx_nxt.seq_state     = cats_pkg::ST_IDLE;
					ctx_nxt.relay_flag    = 1'b0;
					ctx_nxt.complete_flag = 1'b0;
				end
			end
			cats_pkg::ST_RECONF: begin
				ctx_nxt.seq_state     = cats_pkg::ST_END;
				ctx_nxt.relay_flag    = 1'b0;
				ctx_nxt.complete_flag = 1'b1;
				ctx_nxt.command_time  = '0;
			end
			default: begin
				ctx_nxt.seq_state     = cats_pkg::ST_IDLE;
				ctx_nxt.relay_flag    = 1'b0;
				ctx_nxt.complete_flag = 1'b0;
			end
		endcase

		ctx_nxt.last_code = tick.test_code;
		// The pulse edge detector only follows the state while the driver is in test mode.
		if (tick.driver_in_test_mode) begin
			ctx_nxt.last_state = ctx_nxt.seq_state;
		end
	end

	assign may_pulse  = is_coil && (idx != cats_pkg::COIL_FOUR || tick.four_cylinder_engine);
	assign pulse_prod = {10'd0, ctx_nxt.command_time} * {8'd0, cats_pkg::PULSE_SCALE};

	always_comb begin
		res.test_state      = ctx_nxt.seq_state;
		res.relay_command   = ctx_nxt.relay_flag;
		res.test_complete   = ctx_nxt.complete_flag;
		res.coil_done       = (ctx_nxt.complete_flag && is_coil) ? 4'(1) << idx : 4'd0;
		res.pulse_start     = tick.driver_in_test_mode && may_pulse &&
			ctx_nxt.seq_state == cats_pkg::ST_ON && ctx.last_state != cats_pkg::ST_ON;
		res.pulse_coil      = res.pulse_start ? idx : 2'd0;
		res.pulse_time      = res.pulse_start ? pulse_prod[17:1] : '0;
		res.enter_test_mode = is_coil && ctx_nxt.seq_state == cats_pkg::ST_START;
		res.leave_test_mode = is_coil && (ctx_nxt.seq_state == cats_pkg::ST_STOP ||
			ctx_nxt.seq_state == cats_pkg::ST_RECONF);
	end

endmodule

// ===== design/coil_actuator_test_sequencer.sv =====
// ----------------------------------------------------------------------------
// coil_actuator_test_sequencer: ignition coil actuator test sequencer
// Steps a seven-state test sequence once per tick beat and reports the relay,
// completion and driver pulse requests for that tick.
// ----------------------------------------------------------------------------
// Usage:
//   tick   - one beat per sequencer tick (enable, code, driver mode, cylinders).
//   result - one beat per tick beat, in order, with the state after that tick.
//   cfg    - register writes (index 0..7); always ready. Write only while no
//            tick is in flight.
// Data path: a tick beat is held in an input register, stepped by a single pass
// of combinational logic, and the new context and the result are registered
// together in the output register that drives result. Throughput is one tick
// per cycle while result is not stalled.
// A stalled result holds the output register; the input register still takes
// one more beat, after which tick.ready falls until the result is taken.
// Reset returns the sequencer to idle with all counters and flags cleared,
// the timing registers to zero and the coil codes to one to four.
// ----------------------------------------------------------------------------
module coil_actuator_test_sequencer #(
	parameter int unsigned SAMPLE_PERIOD = 10
) (
	input  logic         clk,
	input  logic         arst_n,
	cats_tick_if.sink    tick,
	cats_result_if.source result,
	cats_cfg_if.sink     cfg
);

	cats_pkg::cfg_t    regs;
	cats_pkg::ctx_t    ctx_q;
	cats_pkg::ctx_t    ctx_nxt;
	cats_pkg::tick_t   tick_s1;
	logic              valid_s1;
	cats_pkg::result_t res;
	cats_pkg::result_t res_s2;
	logic              valid_s2;
	logic              out_free;
	logic              advance;

	cats_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	cats_step #(
		.SAMPLE_PERIOD (SAMPLE_PERIOD)
	) u_step (
		.regs    (regs),
		.ctx     (ctx_q),
		.tick    (tick_s1),
		.ctx_nxt (ctx_nxt),
		.res     (res)
	);

	assign out_free   = !valid_s2 || result.ready;
	assign advance    = valid_s1 && out_free;
	assign tick.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.ready && tick.valid) begin
			tick_s1.test_enable          <= tick.test_enable;
			tick_s1.test_code            <= tick.test_code;
			tick_s1.driver_in_test_mode  <= tick.driver_in_test_mode;
			tick_s1.four_cylinder_engine <= tick.four_cylinder_engine;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q.seq_state       <= cats_pkg::ST_IDLE;
			ctx_q.last_state      <= cats_pkg::ST_IDLE;
			ctx_q.last_code       <= cats_pkg::CODE_ONE_RST;
			ctx_q.hold_count      <= '0;
			ctx_q.remaining_ticks <= '0;
			ctx_q.command_time    <= '0;
			ctx_q.interval_time   <= '0;
			ctx_q.relay_flag      <= 1'b0;
			ctx_q.complete_flag   <= 1'b0;
		end else if (advance) begin
			ctx_q <= ctx_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign result.valid           = valid_s2;
	assign result.test_state      = res_s2.test_state;
	assign result.relay_command   = res_s2.relay_command;
	assign result.test_complete   = res_s2.test_complete;
	assign result.coil_done       = res_s2.coil_done;
	assign result.pulse_start     = res_s2.pulse_start;
	assign result.pulse_coil      = res_s2.pulse_coil;
	assign result.pulse_time      = res_s2.pulse_time;
	assign result.enter_test_mode = res_s2.enter_test_mode;
	assign result.leave_test_mode = res_s2.leave_test_mode;

endmodule

// ===== design/cats_checker.sv =====
// ----------------------------------------------------------------------------
// cats_checker: port-level checks of the test sequencer results
// Watches the result channel and checks consistency between its fields.
// ----------------------------------------------------------------------------
module cats_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        ready,
	input logic [2:0]  test_state,
	input logic        test_complete,
	input logic [3:0]  coil_done,
	input logic        pulse_start,
	input logic [1:0]  pulse_coil,
	input logic [16:0] pulse_time,
	input logic        enter_test_mode,
	input logic        leave_test_mode
);

	// A stalled beat must stay offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid)
		else $error("result beat withdrawn while stalled");

	// Coil completion is only reported alongside the completion flag, one coil at most.
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid && coil_done != 4'd0 |-> test_complete && $onehot(coil_done))
		else $error("coil_done inconsistent with test_complete");

	// Pulse fields are zero without a pulse, and a pulse only comes in the on state.
	a_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (pulse_start ? test_state == cats_pkg::ST_ON :
			(pulse_coil == 2'd0 && pulse_time == 17'd0)))
		else $error("pulse fields inconsistent");

	a_modes: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (!enter_test_mode || test_state == cats_pkg::ST_START) &&
			(!leave_test_mode || test_state == cats_pkg::ST_STOP ||
			test_state == cats_pkg::ST_RECONF))
		else $error("mode request in wrong state");

endmodule

bind coil_actuator_test_sequencer cats_checker u_cats_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.valid           (result.valid),
	.ready           (result.ready),
	.test_state      (result.test_state),
	.test_complete   (result.test_complete),
	.coil_done       (result.coil_done),
	.pulse_start     (result.pulse_start),
	.pulse_coil      (result.pulse_coil),
	.pulse_time      (result.pulse_time),
	.enter_test_mode (result.enter_test_mode),
	.leave_test_mode (result.leave_test_mode)
);

// ===== test/coil_actuator_test_sequencer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// coil_actuator_test_sequencer_tb: self-checking bench for the coil test sequencer
// A scoreboard class steps its own copy of the sequencer on every accepted tick
// beat and checks each result beat, field by field, in order. Stimulus is a
// short directed run followed by random test sequences under several register
// settings, with random idling and stalls on both channels.
// ----------------------------------------------------------------------------
module coil_actuator_test_sequencer_tb;

	localparam int unsigned SAMPLE_PERIOD = 10;
	localparam int unsigned CLK_PERIOD    = 20;
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned PHASES        = 9;
	localparam int unsigned LONG_STALL    = 80;

	class coil_test_tracker;
		cats_pkg::cfg_t    regs;
		cats_pkg::ctx_t    ctx;
		cats_pkg::result_t expected_beats[$];
		int unsigned       mismatches;
		int unsigned       beats;

		function new();
			regs = '0;
			regs.code_coil_one   = cats_pkg::CODE_ONE_RST;
			regs.code_coil_two   = cats_pkg::CODE_TWO_RST;
			regs.code_coil_three = cats_pkg::CODE_THREE_RST;
			regs.code_coil_four  = cats_pkg::CODE_FOUR_RST;
			ctx = '0;
			ctx.seq_state  = cats_pkg::ST_IDLE;
			ctx.last_state = cats_pkg::ST_IDLE;
			ctx.last_code  = cats_pkg::CODE_ONE_RST;
			mismatches = 0;
			beats = 0;
		endfunction

		function logic [cats_pkg::TICK_W-1:0] clamp_ticks(int unsigned v);
			return (v > cats_pkg::TICK_LIMIT) ? cats_pkg::TICK_LIMIT :
				v[cats_pkg::TICK_W-1:0];
		endfunction

		function int unsigned pending();
			return expected_beats.size();
		endfunction

		function void write_reg(cats_pkg::cfg_reg_t idx, logic [15:0] data);
			case (idx)
				cats_pkg::REG_ON_TIME:         regs.on_time = data[7:0];
				cats_pkg::REG_OFF_TIME:        regs.off_time = data;
				cats_pkg::REG_TOTAL_TIME:      regs.total_time = data;
				cats_pkg::REG_IDLE_HOLD:       regs.idle_hold = data;
				cats_pkg::REG_CODE_COIL_ONE:   regs.code_coil_one = data[7:0];
				cats_pkg::REG_CODE_COIL_TWO:   regs.code_coil_two = data[7:0];
				cats_pkg::REG_CODE_COIL_THREE: regs.code_coil_three = data[7:0];
				cats_pkg::REG_CODE_COIL_FOUR:  regs.code_coil_four = data[7:0];
				default: ;
			endcase
		endfunction

		// Slot 4 means the code matches no coil; the first match wins.
		function int unsigned coil_slot(logic [7:0] code);
			if (code == regs.code_coil_one) return 0;
			if (code == regs.code_coil_two) return 1;
			if (code == regs.code_coil_three) return 2;
			if (code == regs.code_coil_four) return 3;
			return 4;
		endfunction

		function void abort_test();
			ctx.seq_state = cats_pkg::ST_STOP;
			ctx.relay_flag = 1'b1;
			ctx.complete_flag = 1'b0;
			ctx.command_time = '0;
		endfunction

		function void wind_up_test();
			ctx.seq_state = cats_pkg::ST_RECONF;
			ctx.relay_flag = 1'b1;
			ctx.complete_flag = 1'b0;
		endfunction

		function void rest_in_idle();
			ctx.hold_count = clamp_ticks(32'(regs.idle_hold));
			ctx.seq_state = cats_pkg::ST_IDLE;
			ctx.relay_flag = 1'b0;
			ctx.complete_flag = 1'b0;
		endfunction

		function void note_tick(cats_pkg::tick_t t);
			int unsigned       slot;
			int unsigned       sum;
			bit                is_coil;
			bit                ena;
			bit                broken;
			cats_pkg::result_t r;
			slot = coil_slot(t.test_code);
			is_coil = slot < 4;
			ena = t.test_enable && is_coil;
			broken = !ena || (t.test_code != ctx.last_code);
			r = '0;
			case (ctx.seq_state)
				cats_pkg::ST_IDLE: begin
					if (ena && ctx.hold_count == 0) begin
						ctx.seq_state = cats_pkg::ST_START;
						ctx.relay_flag = 1'b1;
						ctx.complete_flag = 1'b0;
					end else if (ctx.hold_count > 0) begin
						ctx.hold_count = ctx.hold_count - 1'b1;
					end
				end
				cats_pkg::ST_START: begin
					if (ena) begin
						ctx.remaining_ticks = clamp_ticks(32'(regs.total_time));
						ctx.relay_flag = 1'b1;
						ctx.complete_flag = 1'b0;
						ctx.seq_state = cats_pkg::ST_ON;
						ctx.command_time = regs.on_time;
					end
				end
				cats_pkg::ST_ON: begin
					if (broken) begin
						abort_test();
					end else if (ctx.remaining_ticks <= 1) begin
						wind_up_test();
					end else begin
						if (ctx.command_time <= SAMPLE_PERIOD) begin
							// The unused part of the on phase is carried into the off interval.
							sum = 32'(ctx.command_time) + 32'(regs.off_time);
							sum = (sum > SAMPLE_PERIOD) ? sum - SAMPLE_PERIOD : 0;
							ctx.seq_state = cats_pkg::ST_OFF;
							ctx.interval_time = (sum > cats_pkg::INTERVAL_LIMIT) ?
								cats_pkg::INTERVAL_LIMIT : sum[15:0];
							ctx.command_time = '0;
						end else begin
							ctx.command_time = ctx.command_time - 8'(SAMPLE_PERIOD);
						end
						ctx.remaining_ticks = ctx.remaining_ticks - 1'b1;
					end
				end
				cats_pkg::ST_OFF: begin
					if (broken) begin
						abort_test();
					end else if (ctx.remaining_ticks <= 1) begin
						wind_up_test();
					end else begin
						if (ctx.interval_time <= SAMPLE_PERIOD) begin
							ctx.seq_state = cats_pkg::ST_ON;
							ctx.command_time = regs.on_time;
						end else begin
							ctx.interval_time = ctx.interval_time - 16'(SAMPLE_PERIOD);
						end
						ctx.remaining_ticks = ctx.remaining_ticks - 1'b1;
					end
				end
				cats_pkg::ST_STOP: rest_in_idle();
				cats_pkg::ST_END: begin
					if (ena) rest_in_idle();
				end
				cats_pkg::ST_RECONF: begin
					ctx.seq_state = cats_pkg::ST_END;
					ctx.relay_flag = 1'b0;
					ctx.complete_flag = 1'b1;
					ctx.command_time = '0;
				end
				default: begin
					ctx.seq_state = cats_pkg::ST_IDLE;
					ctx.relay_flag = 1'b0;
					ctx.complete_flag = 1'b0;
				end
			endcase

			if (ctx.complete_flag && is_coil) r.coil_done = 4'b0001 << slot;
			ctx.last_code = t.test_code;
			r.enter_test_mode = is_coil && (ctx.seq_state == cats_pkg::ST_START);

			// The pulse goes out once on entry to the on state, seen by the driver.
			if (t.driver_in_test_mode) begin
				if ((slot <= 2 || (slot == 3 && t.four_cylinder_engine)) &&
					ctx.seq_state == cats_pkg::ST_ON && ctx.last_state != cats_pkg::ST_ON) begin
					sum = 32'(ctx.command_time);
					sum = sum * 32'(cats_pkg::PULSE_SCALE) / 2;
					r.pulse_start = 1'b1;
					r.pulse_coil = slot[1:0];
					r.pulse_time = sum[cats_pkg::PULSE_W-1:0];
				end
				ctx.last_state = ctx.seq_state;
			end

			r.leave_test_mode = is_coil &&
				(ctx.seq_state == cats_pkg::ST_STOP || ctx.seq_state == cats_pkg::ST_RECONF);
			r.test_state = ctx.seq_state;
			r.relay_command = ctx.relay_flag;
			r.test_complete = ctx.complete_flag;
			expected_beats.push_back(r);
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= 10) $display("mismatch: %s", msg);
		endfunction

		function void compare_field(string name, logic [16:0] want, logic [16:0] got);
			if (want !== got)
				report($sformatf("beat %0d %s: expected %0d, got %0d", beats, name, want, got));
		endfunction

		function void check_beat(cats_pkg::result_t got);
			cats_pkg::result_t want;
			beats++;
			if (expected_beats.size() == 0) begin
				report($sformatf("result beat %0d arrived with nothing expected", beats));
				return;
			end
			want = expected_beats.pop_front();
			compare_field("test_state", 17'(want.test_state), 17'(got.test_state));
			compare_field("relay_command", 17'(want.relay_command), 17'(got.relay_command));
			compare_field("test_complete", 17'(want.test_complete), 17'(got.test_complete));
			compare_field("coil_done", 17'(want.coil_done), 17'(got.coil_done));
			compare_field("pulse_start", 17'(want.pulse_start), 17'(got.pulse_start));
			compare_field("pulse_coil", 17'(want.pulse_coil), 17'(got.pulse_coil));
			compare_field("pulse_time", want.pulse_time, got.pulse_time);
			compare_field("enter_test_mode", 17'(want.enter_test_mode),
				17'(got.enter_test_mode));
			compare_field("leave_test_mode", 17'(want.leave_test_mode),
				17'(got.leave_test_mode));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	cats_tick_if   tick_bus();
	cats_result_if result_bus();
	cats_cfg_if    cfg_bus();

	coil_test_tracker tracker = new();

	logic [15:0] reg_plan [0:7];
	bit          tx_steady;
	bit          rx_steady;
	bit          rx_long_hold;

	coil_actuator_test_sequencer #(
		.SAMPLE_PERIOD(SAMPLE_PERIOD)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.tick(tick_bus),
		.result(result_bus),
		.cfg(cfg_bus)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic cats_pkg::tick_t make_tick(logic en, logic [7:0] code, logic drv,
		logic four);
		cats_pkg::tick_t t;
		t.test_enable = en;
		t.test_code = code;
		t.driver_in_test_mode = drv;
		t.four_cylinder_engine = four;
		return t;
	endfunction

	function automatic logic [7:0] pick_coil_code();
		case ($urandom_range(0, 3))
			0: return tracker.regs.code_coil_one;
			1: return tracker.regs.code_coil_two;
			2: return tracker.regs.code_coil_three;
			default: return tracker.regs.code_coil_four;
		endcase
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (tx_steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Narrow registers get junk in the upper byte, which must be dropped.
	function automatic logic [15:0] byte_reg(logic [7:0] v);
		logic [7:0] junk;
		junk = 8'($urandom_range(0, 255));
		return {junk, v};
	endfunction

	function automatic void plan_registers(int unsigned phase);
		logic [7:0] c1, c2, c3, c4;
		case (phase)
			1: begin
				reg_plan[cats_pkg::REG_ON_TIME]    = byte_reg(8'd25);
				reg_plan[cats_pkg::REG_OFF_TIME]   = 16'd40;
				reg_plan[cats_pkg::REG_TOTAL_TIME] = 16'd120;
				reg_plan[cats_pkg::REG_IDLE_HOLD]  = 16'd5;
				c1 = 8'd1; c2 = 8'd2; c3 = 8'd3; c4 = 8'd4;
			end
			2: begin
				reg_plan[cats_pkg::REG_ON_TIME]    = byte_reg(8'd0);
				reg_plan[cats_pkg::REG_OFF_TIME]   = 16'd0;
				reg_plan[cats_pkg::REG_TOTAL_TIME] = 16'd0;
				reg_plan[cats_pkg::REG_IDLE_HOLD]  = 16'd0;
				c1 = 8'd0; c2 = 8'd255; c3 = 8'd0; c4 = 8'd255;
			end
			3: begin
				reg_plan[cats_pkg::REG_ON_TIME]    = byte_reg(8'd255);
				reg_plan[cats_pkg::REG_OFF_TIME]   = 16'hFFFF;
				reg_plan[cats_pkg::REG_TOTAL_TIME] = 16'hFFFF;
				reg_plan[cats_pkg::REG_IDLE_HOLD]  = 16'hFFFF;
				c1 = 8'd255; c2 = 8'd254; c3 = 8'd253; c4 = 8'd252;
			end
			default: begin
				reg_plan[cats_pkg::REG_ON_TIME] = byte_reg(8'(($urandom_range(0, 1) == 0) ?
					$urandom_range(0, 40) : $urandom_range(0, 255)));
				if ($urandom_range(0, 9) < 6)
					reg_plan[cats_pkg::REG_OFF_TIME] = 16'($urandom_range(0, 60));
				else if ($urandom_range(0, 9) < 7)
					reg_plan[cats_pkg::REG_OFF_TIME] = 16'($urandom_range(0, 600));
				else
					reg_plan[cats_pkg::REG_OFF_TIME] = 16'($urandom_range(0, 65535));
				reg_plan[cats_pkg::REG_TOTAL_TIME] = 16'(($urandom_range(0, 9) < 8) ?
					$urandom_range(0, 200) : $urandom_range(0, 600));
				reg_plan[cats_pkg::REG_IDLE_HOLD] = 16'(($urandom_range(0, 9) < 8) ?
					$urandom_range(0, 15) : $urandom_range(0, 60));
				c1 = 8'($urandom_range(0, 255));
				c2 = 8'($urandom_range(0, 255));
				c3 = 8'($urandom_range(0, 255));
				c4 = 8'($urandom_range(0, 255));
				if ($urandom_range(0, 4) == 0) c4 = c1;
				if ($urandom_range(0, 4) == 0) c3 = c2;
			end
		endcase
		reg_plan[cats_pkg::REG_CODE_COIL_ONE]   = byte_reg(c1);
		reg_plan[cats_pkg::REG_CODE_COIL_TWO]   = byte_reg(c2);
		reg_plan[cats_pkg::REG_CODE_COIL_THREE] = byte_reg(c3);
		reg_plan[cats_pkg::REG_CODE_COIL_FOUR]  = byte_reg(c4);
	endfunction

	task automatic write_reg_plan();
		cats_pkg::cfg_reg_t idx;
		idx = cats_pkg::REG_ON_TIME;
		forever begin
			cfg_bus.valid <= 1'b1;
			cfg_bus.index <= idx;
			cfg_bus.data <= reg_plan[idx];
			@(posedge clk);
			while (!cfg_bus.ready) @(posedge clk);
			tracker.write_reg(idx, reg_plan[idx]);
			if (idx == cats_pkg::REG_CODE_COIL_FOUR) break;
			idx = idx.next();
		end
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic offer_tick(input cats_pkg::tick_t t);
		int unsigned gap;
		tick_bus.valid <= 1'b1;
		tick_bus.test_enable <= t.test_enable;
		tick_bus.test_code <= t.test_code;
		tick_bus.driver_in_test_mode <= t.driver_in_test_mode;
		tick_bus.four_cylinder_engine <= t.four_cylinder_engine;
		@(posedge clk);
		while (!tick_bus.ready) @(posedge clk);
		tracker.note_tick(t);
		gap = pick_gap();
		if (gap > 0) begin
			tick_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop offering ticks and let every outstanding result come back.
	task automatic drain();
		tick_bus.valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Runs under the reset settings: on, off and total time all zero, codes one to four.
	task automatic directed_ticks();
		offer_tick(make_tick(1'b0, 8'h00, 1'b0, 1'b0));
		offer_tick(make_tick(1'b1, 8'hFF, 1'b1, 1'b1));
		offer_tick(make_tick(1'b0, 8'd1, 1'b1, 1'b0));
		// A full test on coil one: start, on with a pulse, reconfigure, end.
		repeat (4) offer_tick(make_tick(1'b1, 8'd1, 1'b1, 1'b0));
		offer_tick(make_tick(1'b0, 8'd2, 1'b1, 1'b0));
		offer_tick(make_tick(1'b1, 8'd9, 1'b1, 1'b0));
		offer_tick(make_tick(1'b1, 8'd4, 1'b1, 1'b0));
		// Coil four without the four cylinder flag gets no pulse.
		offer_tick(make_tick(1'b1, 8'd4, 1'b1, 1'b0));
		offer_tick(make_tick(1'b1, 8'd4, 1'b1, 1'b0));
		// The code changes while on, so the test stops.
		offer_tick(make_tick(1'b1, 8'd3, 1'b1, 1'b0));
		offer_tick(make_tick(1'b1, 8'd3, 1'b1, 1'b0));
		offer_tick(make_tick(1'b1, 8'd4, 1'b1, 1'b1));
		offer_tick(make_tick(1'b1, 8'd4, 1'b1, 1'b1));
		// Dropping the enable while on also stops the test.
		offer_tick(make_tick(1'b0, 8'd4, 1'b1, 1'b1));
		offer_tick(make_tick(1'b1, 8'd2, 1'b0, 1'b1));
		// The driver is not in test mode, so no pulse and no state tracking.
		offer_tick(make_tick(1'b1, 8'd2, 1'b0, 1'b0));
		offer_tick(make_tick(1'b1, 8'd2, 1'b0, 1'b0));
		offer_tick(make_tick(1'b1, 8'd2, 1'b1, 1'b0));
		offer_tick(make_tick(1'b1, 8'd2, 1'b1, 1'b0));
		offer_tick(make_tick(1'b1, 8'd3, 1'b1, 1'b0));
	endtask

	task automatic random_ticks(input int unsigned budget);
		int unsigned     issued;
		int unsigned     kind;
		int unsigned     len;
		int unsigned     full;
		int unsigned     n;
		logic [7:0]      code;
		bit              drv_flaky;
		bit              four;
		cats_pkg::tick_t t;
		issued = 0;
		while (issued < budget) begin
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				// A test on one coil code, mostly held long enough to finish, with rare glitches.
				code = pick_coil_code();
				full = 32'(tracker.clamp_ticks(32'(tracker.regs.total_time))) + 5 +
					$urandom_range(0, 3);
				len = ($urandom_range(0, 9) < 6) ? full : $urandom_range(1, full);
				drv_flaky = ($urandom_range(0, 4) == 0);
				four = 1'($urandom_range(0, 1));
				n = 0;
				while (n < len && issued < budget) begin
					t = make_tick(1'b1, code, drv_flaky ? 1'($urandom_range(0, 1)) : 1'b1,
						four);
					if ($urandom_range(0, 49) == 0) begin
						if ($urandom_range(0, 1) == 0)
							t.test_enable = 1'b0;
						else
							t.test_code = 8'($urandom_range(0, 255));
					end
					offer_tick(t);
					n++;
					issued++;
				end
			end else if (kind < 85) begin
				len = $urandom_range(1, 6);
				n = 0;
				while (n < len && issued < budget) begin
					offer_tick(make_tick(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
					n++;
					issued++;
				end
			end else begin
				len = $urandom_range(1, 8);
				n = 0;
				while (n < len && issued < budget) begin
					if ($urandom_range(0, 1) == 0)
						t = make_tick(1'b0, pick_coil_code(), 1'($urandom_range(0, 1)),
							1'($urandom_range(0, 1)));
					else
						t = make_tick(1'b1, 8'($urandom_range(0, 255)),
							1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
					offer_tick(t);
					n++;
					issued++;
				end
			end
		end
	endtask

	initial begin : result_sink
		int unsigned       stall_left;
		int unsigned       r;
		bit                rdy;
		cats_pkg::result_t got;
		stall_left = 0;
		result_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_bus.valid && result_bus.ready) begin
				got.test_state = cats_pkg::seq_state_t'(result_bus.test_state);
				got.relay_command = result_bus.relay_command;
				got.test_complete = result_bus.test_complete;
				got.coil_done = result_bus.coil_done;
				got.pulse_start = result_bus.pulse_start;
				got.pulse_coil = result_bus.pulse_coil;
				got.pulse_time = result_bus.pulse_time;
				got.enter_test_mode = result_bus.enter_test_mode;
				got.leave_test_mode = result_bus.leave_test_mode;
				tracker.check_beat(got);
			end
			if (rx_long_hold) begin
				rx_long_hold = 1'b0;
				stall_left = LONG_STALL;
			end
			if (stall_left > 0) begin
				stall_left--;
				rdy = 1'b0;
			end else if (rx_steady) begin
				rdy = 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				rdy = (r < 70);
				if (r >= 70 && r < 95)
					stall_left = $urandom_range(0, 2);
				else if (r >= 95)
					stall_left = $urandom_range(10, 40);
			end
			result_bus.ready <= rdy;
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin : stimulus
		int unsigned budget;
		arst_n <= 1'b0;
		tick_bus.valid <= 1'b0;
		tick_bus.test_enable <= 1'b0;
		tick_bus.test_code <= '0;
		tick_bus.driver_in_test_mode <= 1'b0;
		tick_bus.four_cylinder_engine <= 1'b0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.index <= cats_pkg::REG_ON_TIME;
		cfg_bus.data <= '0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		rx_long_hold = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int unsigned phase = 0; phase < PHASES; phase++) begin
			if (phase > 0) begin
				plan_registers(phase);
				write_reg_plan();
			end
			// One phase runs flat out on both sides; another holds off the
			// receiver while ticks keep coming, so the input backs up.
			tx_steady = (phase == 2) || (phase == 4);
			rx_steady = (phase == 2);
			if (phase == 4) rx_long_hold = 1'b1;
			if (phase == 0) directed_ticks();
			case (phase)
				0: budget = 80;
				1: budget = 150;
				3: budget = 250;
				default: budget = 125;
			endcase
			random_ticks(budget);
			drain();
		end

		repeat (8) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
